// ===== rtl/tmr_pkg.sv =====
// ----------------------------------------------------------------------------
// tmr_pkg
// Shared types and constants of the multi-channel timer: item modes,
// sequencer states and the layout of one channel table entry.
// ----------------------------------------------------------------------------
package tmr_pkg;

	localparam int TIME_W = 32;
	localparam int ID_W   = 4;

	// Only ids that fit in the timer_id field can ever be armed.
	localparam int ADDR_LIMIT = 1 << ID_W;

	typedef enum logic [1:0] {
		MODE_SET  = 2'd0,
		MODE_KILL = 2'd1,
		MODE_TICK = 2'd2,
		MODE_POLL = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_CHECK,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [TIME_W-1:0] period;
		logic [TIME_W-1:0] start;
		logic              once;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== rtl/tmr_ram.sv =====
// ----------------------------------------------------------------------------
// tmr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tmr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/tmr_cmp.sv =====
// ----------------------------------------------------------------------------
// tmr_cmp
// Shared subtract-compare unit: decides whether a channel has expired from
// its wrapped elapsed time and its period.
// ----------------------------------------------------------------------------
module tmr_cmp (
	input  logic [tmr_pkg::TIME_W-1:0] now,
	input  logic [tmr_pkg::TIME_W-1:0] start,
	input  logic [tmr_pkg::TIME_W-1:0] period,
	output logic                       expired
);

	logic [tmr_pkg::TIME_W-1:0] elapsed;

	// The subtraction wraps modulo 2^32, which handles counter rollover.
	assign elapsed = now - start;
	assign expired = (elapsed >= period);

endmodule

// ===== rtl/multi_channel_software_timer.sv =====
// ----------------------------------------------------------------------------
// multi_channel_software_timer
// Table of one-shot or periodic timer channels driven by tick words, with a
// poll that reports and services the lowest expired channel.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake          | Fields
//  --------+--------------------+--------------------------------------------
//  input   | in_valid/in_stall  | mode, timer_id, period_ms, one_shot
//  output  | out_valid/out_stall| fired, fired_id
//
// Set, kill and tick words pass through the final state and back to idle. A
// poll word scans the channels from the lowest index up to a hit or the end of
// the table; each valid channel costs one read of the channel RAM and one pass
// through the subtract-compare unit, and a free channel is skipped without a
// compare. The final state then hands the result to the output register.
// Reset clears all valid marks and the time counter at once; no clearing pass.
// A stalled result holds the block in its final state until it is taken.
//
module multi_channel_software_timer #(
	parameter int NUM_TIMERS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 mode,
	input  logic [tmr_pkg::ID_W-1:0]   timer_id,
	input  logic [tmr_pkg::TIME_W-1:0] period_ms,
	input  logic                       one_shot,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       fired,
	output logic [tmr_pkg::ID_W-1:0]   fired_id
);

	localparam int IDX_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int SCAN_N = (NUM_TIMERS < tmr_pkg::ADDR_LIMIT) ? NUM_TIMERS
		: tmr_pkg::ADDR_LIMIT;

	tmr_pkg::state_t state_q, state_d;
	tmr_pkg::mode_t  mode_in;
	tmr_pkg::mode_t  mode_q;

	logic [NUM_TIMERS-1:0]      valid_q;
	logic [tmr_pkg::TIME_W-1:0] now_q;
	logic [IDX_W-1:0]           idx_q;
	logic                       res_fired_q;
	logic [tmr_pkg::ID_W-1:0]   res_id_q;
	logic                       out_valid_q;
	logic                       fired_q;
	logic [tmr_pkg::ID_W-1:0]   fired_id_q;

	logic                       accept;
	logic                       id_ok;
	logic [IDX_W-1:0]           id_idx;
	logic                       last_idx;
	logic                       out_free;
	logic                       expired;

	logic                       ram_we;
	logic [IDX_W-1:0]           ram_waddr;
	tmr_pkg::entry_t            ram_wdata;
	logic [tmr_pkg::ENTRY_W-1:0] ram_rdata;
	tmr_pkg::entry_t            rd_entry;

	// Control decided by the sequencer for this cycle.
	logic set_valid, clr_valid, tick, idx_clr, idx_inc, hit, load_out;
	logic [IDX_W-1:0] valid_addr;

	assign mode_in  = tmr_pkg::mode_t'(mode);
	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != tmr_pkg::S_IDLE);
	assign id_ok    = (32'(timer_id) < 32'(NUM_TIMERS));
	assign id_idx   = IDX_W'(timer_id);
	assign last_idx = (idx_q == IDX_W'(SCAN_N - 1));
	assign out_free = !out_valid_q || !out_stall;
	assign rd_entry = tmr_pkg::entry_t'(ram_rdata);

	tmr_ram #(
		.WIDTH (tmr_pkg::ENTRY_W),
		.DEPTH (NUM_TIMERS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (tmr_pkg::ENTRY_W'(ram_wdata)),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	tmr_cmp u_cmp (
		.now     (now_q),
		.start   (rd_entry.start),
		.period  (rd_entry.period),
		.expired (expired)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tmr_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		set_valid  = 1'b0;
		clr_valid  = 1'b0;
		valid_addr = id_idx;
		tick       = 1'b0;
		idx_clr    = 1'b0;
		idx_inc    = 1'b0;
		hit        = 1'b0;
		load_out   = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = id_idx;
		ram_wdata  = '{period: period_ms, start: now_q, once: one_shot};
		unique case (state_q)
			tmr_pkg::S_IDLE: begin
				if (accept) begin
					idx_clr = 1'b1;
					unique case (mode_in)
						tmr_pkg::MODE_SET: begin
							set_valid = id_ok;
							ram_we    = id_ok;
							state_d   = tmr_pkg::S_DONE;
						end
						tmr_pkg::MODE_KILL: begin
							clr_valid = id_ok;
							state_d   = tmr_pkg::S_DONE;
						end
						tmr_pkg::MODE_TICK: begin
							tick    = 1'b1;
							state_d = tmr_pkg::S_DONE;
						end
						tmr_pkg::MODE_POLL: begin
							state_d = tmr_pkg::S_SCAN;
						end
						default: state_d = tmr_pkg::S_DONE;
					endcase
				end
			end
			tmr_pkg::S_SCAN: begin
				// The RAM read at idx_q is issued here; skip free channels.
				if (valid_q[idx_q]) begin
					state_d = tmr_pkg::S_CHECK;
				end else if (last_idx) begin
					state_d = tmr_pkg::S_DONE;
				end else begin
					idx_inc = 1'b1;
				end
			end
			tmr_pkg::S_CHECK: begin
				valid_addr = idx_q;
				ram_waddr  = idx_q;
				ram_wdata  = '{period: rd_entry.period, start: now_q, once: 1'b0};
				if (expired) begin
					hit       = 1'b1;
					clr_valid = rd_entry.once;
					ram_we    = !rd_entry.once;
					state_d   = tmr_pkg::S_DONE;
				end else if (last_idx) begin
					state_d = tmr_pkg::S_DONE;
				end else begin
					idx_inc = 1'b1;
					state_d = tmr_pkg::S_SCAN;
				end
			end
			tmr_pkg::S_DONE: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = tmr_pkg::S_IDLE;
				end
			end
			default: state_d = tmr_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			now_q       <= '0;
			out_valid_q <= 1'b0;
			res_fired_q <= 1'b0;
			mode_q      <= tmr_pkg::MODE_SET;
		end else begin
			if (set_valid) begin
				valid_q[valid_addr] <= 1'b1;
			end else if (clr_valid) begin
				valid_q[valid_addr] <= 1'b0;
			end
			if (tick) begin
				now_q <= now_q + 1'b1;
			end
			if (accept) begin
				mode_q      <= mode_in;
				res_fired_q <= 1'b0;
			end else if (hit) begin
				res_fired_q <= 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (idx_clr) begin
			idx_q <= '0;
		end else if (idx_inc) begin
			idx_q <= idx_q + 1'b1;
		end
		if (accept) begin
			res_id_q <= '0;
		end else if (hit) begin
			res_id_q <= tmr_pkg::ID_W'(idx_q);
		end
		if (load_out) begin
			fired_q    <= res_fired_q;
			fired_id_q <= res_id_q;
		end
	end

	assign out_valid = out_valid_q;
	assign fired     = fired_q;
	assign fired_id  = fired_id_q;

	// A channel is only compared after its RAM read was issued.
	a_check_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tmr_pkg::S_CHECK |-> $past(state_q) == tmr_pkg::S_SCAN)
		else $error("compare state entered without a RAM read");

	// Only a poll can produce a hit.
	a_hit_only_poll: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tmr_pkg::S_DONE && res_fired_q) |-> mode_q == tmr_pkg::MODE_POLL)
		else $error("hit recorded for a word that is not a poll");

	// A tick word advances the time counter by exactly one.
	a_tick_step: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && mode_in == tmr_pkg::MODE_TICK) |=> now_q == $past(now_q) + 1'b1)
		else $error("time counter did not advance on a tick");

	// A result is loaded only when the output register can take it.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!out_valid_q || !out_stall))
		else $error("pending result overwritten");

endmodule
